// ===== sv/tfd_pkg.sv =====
// Package for the timestamped frame deframer: phase and event codes,
// framing constants and the structs passed between the parser and output stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

	// Framing bytes
	localparam logic [7:0] START_BYTE = 8'h06;
	localparam logic [7:0] CR_BYTE    = 8'h0D;
	localparam logic [7:0] LF_BYTE    = 8'h0A;
	localparam logic [7:0] LONG_FLAG  = 8'h80;
	localparam logic [7:0] LOW7_MASK  = 8'h7F;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned LEN_W   = 15;
	localparam int unsigned EV_W    = 3;
	localparam int unsigned TDATA_W = 56;

	typedef enum logic [2:0] {
		PH_SYNC  = 3'd0,
		PH_STAMP = 3'd1,
		PH_LEN1  = 3'd2,
		PH_LEN2  = 3'd3,
		PH_DATA  = 3'd4,
		PH_ERROR = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_QUIET   = 3'd0,
		EV_SYNCOK  = 3'd1,
		EV_SYNCERR = 3'd2,
		EV_NULL    = 3'd3,
		EV_HEADER  = 3'd4,
		EV_DATA    = 3'd5,
		EV_DROP    = 3'd6
	} event_t;

	typedef struct packed {
		event_t             ev;
		logic [STAMP_W-1:0] timestamp;
		logic [LEN_W-1:0]   frame_length;
		logic [BYTE_W-1:0]  data_byte;
		logic               last;
	} result_t;

	typedef struct packed {
		phase_t phase;
		logic   in_error;
	} parse_status_t;

endpackage

`default_nettype wire

// ===== sv/tfd_parse.sv =====
// Frame parser: phase state machine, timestamp shift register and length counter.
// Updates state on each advancing word and gives that word's result combinationally.
// Depends on tfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfd_parse (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         advance,
	input  wire [7:0]                   rx_byte,
	output tfd_pkg::result_t            result,
	output tfd_pkg::parse_status_t      status
);

	tfd_pkg::phase_t  phase_q, phase_d;
	logic [1:0]       hdr_idx_q, hdr_idx_d;
	logic [31:0]      stamp_q, stamp_d;
	logic [6:0]       len_high_q, len_high_d;
	logic [14:0]      left_q, left_d;
	logic [14:0]      left_dec;
	logic [14:0]      long_len;

	assign left_dec = left_q - 15'd1;
	assign long_len = {len_high_q, rx_byte};

	// Next state
	always_comb begin
		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		stamp_d    = stamp_q;
		len_high_d = len_high_q;
		left_d     = left_q;
		case (phase_q)
			tfd_pkg::PH_SYNC: begin
				if (rx_byte == tfd_pkg::CR_BYTE || rx_byte == tfd_pkg::LF_BYTE) begin
					phase_d = tfd_pkg::PH_SYNC;
				end else if (rx_byte == tfd_pkg::START_BYTE) begin
					phase_d   = tfd_pkg::PH_STAMP;
					hdr_idx_d = 2'd0;
				end else begin
					phase_d = tfd_pkg::PH_ERROR;
				end
			end
			tfd_pkg::PH_STAMP: begin
				stamp_d = {stamp_q[23:0], rx_byte};
				if (hdr_idx_q == 2'd3) begin
					hdr_idx_d = 2'd0;
					phase_d   = tfd_pkg::PH_LEN1;
				end else begin
					hdr_idx_d = hdr_idx_q + 2'd1;
				end
			end
			tfd_pkg::PH_LEN1: begin
				if ((rx_byte & tfd_pkg::LONG_FLAG) != 8'd0) begin
					len_high_d = rx_byte[6:0];
					phase_d    = tfd_pkg::PH_LEN2;
				end else if (rx_byte != 8'd0) begin
					left_d  = {7'd0, rx_byte};
					phase_d = tfd_pkg::PH_DATA;
				end else begin
					phase_d   = tfd_pkg::PH_STAMP;
					hdr_idx_d = 2'd0;
				end
			end
			tfd_pkg::PH_LEN2: begin
				if (long_len == 15'd0) begin
					phase_d   = tfd_pkg::PH_STAMP;
					hdr_idx_d = 2'd0;
				end else begin
					left_d  = long_len;
					phase_d = tfd_pkg::PH_DATA;
				end
			end
			tfd_pkg::PH_DATA: begin
				left_d = left_dec;
				if (left_dec == 15'd0) begin
					phase_d   = tfd_pkg::PH_STAMP;
					hdr_idx_d = 2'd0;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Result for the current word
	always_comb begin
		result = '0;
		result.ev = tfd_pkg::EV_QUIET;
		case (phase_q)
			tfd_pkg::PH_SYNC: begin
				if (rx_byte == tfd_pkg::CR_BYTE || rx_byte == tfd_pkg::LF_BYTE) begin
					result.ev = tfd_pkg::EV_QUIET;
				end else if (rx_byte == tfd_pkg::START_BYTE) begin
					result.ev = tfd_pkg::EV_SYNCOK;
				end else begin
					result.ev = tfd_pkg::EV_SYNCERR;
				end
			end
			tfd_pkg::PH_STAMP: begin
				result.ev = tfd_pkg::EV_QUIET;
			end
			tfd_pkg::PH_LEN1: begin
				if ((rx_byte & tfd_pkg::LONG_FLAG) != 8'd0) begin
					result.ev = tfd_pkg::EV_QUIET;
				end else if (rx_byte != 8'd0) begin
					result.ev           = tfd_pkg::EV_HEADER;
					result.timestamp    = stamp_q;
					result.frame_length = {7'd0, rx_byte};
				end else begin
					result.ev        = tfd_pkg::EV_NULL;
					result.timestamp = stamp_q;
				end
			end
			tfd_pkg::PH_LEN2: begin
				result.ev           = tfd_pkg::EV_HEADER;
				result.timestamp    = stamp_q;
				result.frame_length = long_len;
				result.last         = (long_len == 15'd0);
			end
			tfd_pkg::PH_DATA: begin
				result.ev        = tfd_pkg::EV_DATA;
				result.timestamp = stamp_q;
				result.data_byte = rx_byte;
				result.last      = (left_dec == 15'd0);
			end
			default: begin
				result.ev = tfd_pkg::EV_DROP;
			end
		endcase
	end

	// Hold state unless a word advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tfd_pkg::PH_SYNC;
			hdr_idx_q  <= 2'd0;
			stamp_q    <= 32'd0;
			len_high_q <= 7'd0;
			left_q     <= 15'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			hdr_idx_q  <= hdr_idx_d;
			stamp_q    <= stamp_d;
			len_high_q <= len_high_d;
			left_q     <= left_d;
		end
	end

	assign status.phase    = phase_q;
	assign status.in_error = (phase_q == tfd_pkg::PH_ERROR);

endmodule

`default_nettype wire

// ===== sv/tfd_outreg.sv =====
// Result register of the deframer: holds one result word until the sink takes it
// and packs it onto the master stream. Depends on tfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfd_outreg (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	input  tfd_pkg::result_t            in_res,
	output logic                        in_ready,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [tfd_pkg::TDATA_W-1:0] m_tdata,  // timestamp[31:0], frame_length[46:32],
	                                              // data_byte[54:47], zero pad[55]
	output logic [tfd_pkg::EV_W-1:0]    m_tuser,  // event_res[2:0]
	output logic                        m_tlast   // last_of_frame
);

	logic             valid_s2;
	tfd_pkg::result_t res_s2;

	assign in_ready = !valid_s2 || m_tready;

	// Valid flag of the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Load a new result word whenever the stage is free
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s2 <= in_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.data_byte, res_s2.frame_length, res_s2.timestamp};
	assign m_tuser  = res_s2.ev;
	assign m_tlast  = res_s2.last;

endmodule

`default_nettype wire

// ===== sv/timestamped_frame_deframer_core.sv =====
// Top level of the timestamped frame deframer: input register, frame parser
// and result register. Depends on tfd_pkg, tfd_parse and tfd_outreg.
//
// Channel  Dir  Word                          Notes
// s_*      in   tdata[7:0] = rx_byte          one serial byte per word
// m_*      out  tdata = ts/len/data, tuser =  one result word per input word
//               event_res, tlast = last
//
// One result per input word; it is registered in the input register and then in
// the result register, which drives m_tvalid. Sustains one word per clock while
// the sink keeps tready high. Parsing happens as a word moves from the input
// register to the result register, so a stalled word leaves frame state untouched.
// Reset clears the valid flags and puts the parser in sync wait.
// A full input register is held while the result register is stalled.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_frame_deframer_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // rx_byte[7:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // timestamp[31:0], frame_length[46:32],
	                               // data_byte[54:47], zero pad[55]
	output logic [2:0]  m_tuser,   // event_res[2:0]
	output logic        m_tlast    // last_of_frame
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   s2_ready;
	logic                   advance;
	tfd_pkg::result_t       result;
	tfd_pkg::parse_status_t status;

	assign advance  = valid_s1 && s2_ready;
	assign s_tready = !valid_s1 || s2_ready;

	// Input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture the incoming word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	tfd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.result  (result),
		.status  (status)
	);

	tfd_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_res   (result),
		.in_ready (s2_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Error phase is sticky until reset
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_error |=> status.in_error)
		else $error("parser left the error phase");

	// A stalled input word is not lost
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_ready) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input word dropped while stalled");

	// tlast only marks payload or header words
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tuser == tfd_pkg::EV_DATA || m_tuser == tfd_pkg::EV_HEADER))
		else $error("tlast on a word that is neither payload nor header");

	// Length is carried only with a header
	a_len_header: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != tfd_pkg::EV_HEADER) |-> (m_tdata[46:32] == 15'd0))
		else $error("frame length outside a header word");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for timestamped_frame_deframer_core: drives serial bytes as stream words,
// predicts each result word and checks it. Depends on tfd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

	// Track frame state and hold the expected result word for every accepted byte
	class deframe_scoreboard;
		tfd_pkg::phase_t  phase;
		logic [1:0]       stamp_idx;
		logic [31:0]      stamp;
		logic [6:0]       len_hi;
		logic [14:0]      remaining;
		tfd_pkg::result_t results_q[$];
		int               fail_count;

		function new();
			phase      = tfd_pkg::PH_SYNC;
			stamp_idx  = '0;
			stamp      = '0;
			len_hi     = '0;
			remaining  = '0;
			fail_count = 0;
		endfunction

		function int pending();
			return results_q.size();
		endfunction

		// Advance the frame state by one byte and queue the word it yields
		function void note_byte(logic [7:0] b);
			tfd_pkg::result_t r;
			logic [14:0]      len;
			r    = '0;
			r.ev = tfd_pkg::EV_QUIET;
			case (phase)
				tfd_pkg::PH_SYNC: begin
					if (b == tfd_pkg::CR_BYTE || b == tfd_pkg::LF_BYTE) begin
						r.ev = tfd_pkg::EV_QUIET;
					end else if (b == tfd_pkg::START_BYTE) begin
						phase     = tfd_pkg::PH_STAMP;
						stamp_idx = '0;
						r.ev      = tfd_pkg::EV_SYNCOK;
					end else begin
						phase = tfd_pkg::PH_ERROR;
						r.ev  = tfd_pkg::EV_SYNCERR;
					end
				end
				tfd_pkg::PH_STAMP: begin
					stamp = {stamp[23:0], b};
					if (stamp_idx == 2'd3)
						phase = tfd_pkg::PH_LEN1;
					stamp_idx = stamp_idx + 2'd1;
				end
				tfd_pkg::PH_LEN1: begin
					if ((b & tfd_pkg::LONG_FLAG) != 8'h00) begin
						len_hi = b[6:0];
						phase  = tfd_pkg::PH_LEN2;
					end else if (b != 8'h00) begin
						remaining      = {7'd0, b};
						phase          = tfd_pkg::PH_DATA;
						r.ev           = tfd_pkg::EV_HEADER;
						r.timestamp    = stamp;
						r.frame_length = {7'd0, b};
					end else begin
						// short zero length: null frame, next frame follows
						phase       = tfd_pkg::PH_STAMP;
						stamp_idx   = '0;
						r.ev        = tfd_pkg::EV_NULL;
						r.timestamp = stamp;
					end
				end
				tfd_pkg::PH_LEN2: begin
					len         = {len_hi, b};
					r.ev        = tfd_pkg::EV_HEADER;
					r.timestamp = stamp;
					if (len == '0) begin
						// long-form zero length: empty frame, header marks the end
						phase     = tfd_pkg::PH_STAMP;
						stamp_idx = '0;
						r.last    = 1'b1;
					end else begin
						remaining      = len;
						phase          = tfd_pkg::PH_DATA;
						r.frame_length = len;
					end
				end
				tfd_pkg::PH_DATA: begin
					remaining   = remaining - 15'd1;
					r.ev        = tfd_pkg::EV_DATA;
					r.timestamp = stamp;
					r.data_byte = b;
					if (remaining == '0) begin
						phase     = tfd_pkg::PH_STAMP;
						stamp_idx = '0;
						r.last    = 1'b1;
					end
				end
				default: r.ev = tfd_pkg::EV_DROP;
			endcase
			results_q.push_back(r);
		endfunction

		// Compare one result word against the oldest expectation
		function void check_word(logic [55:0] tdata, logic [2:0] tuser, logic tlast);
			tfd_pkg::result_t r;
			if (results_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result word ev=%0d tdata=%h last=%b",
						$realtime, tuser, tdata, tlast);
				return;
			end
			r = results_q.pop_front();
			if (tuser !== r.ev || tdata[31:0] !== r.timestamp ||
			    tdata[46:32] !== r.frame_length || tdata[54:47] !== r.data_byte ||
			    tlast !== r.last) begin
				fail_count++;
				if (fail_count <= 10)
					$display({"%0t: mismatch exp ev=%0d ts=%h len=%0d data=%h last=%b",
						" | got ev=%0d ts=%h len=%0d data=%h last=%b"},
						$realtime, r.ev, r.timestamp, r.frame_length, r.data_byte,
						r.last, tuser, tdata[31:0], tdata[46:32], tdata[54:47], tlast);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	deframe_scoreboard sb = new();
	bit idle_on    = 1'b1;
	int items_sent = 0;
	int stall_left = 0;

	timestamped_frame_deframer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check accepted result words; stall the sink in random bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser, m_tlast);
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 14);
		m_tready <= (stall_left == 0);
	end

	// Offer one byte, possibly after an idle burst, and hold it until accepted
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
		items_sent++;
	endtask

	// Send a header (big-endian stamp, short or long length) and random payload
	task automatic send_frame(input logic [31:0] ts, input logic [14:0] len,
	                          input bit long_form);
		for (int i = 3; i >= 0; i--)
			push_byte(ts[8*i +: 8]);
		if (long_form) begin
			push_byte(tfd_pkg::LONG_FLAG | {1'b0, len[14:8]});
			push_byte(len[7:0]);
		end else begin
			push_byte({1'b0, len[6:0]});
		end
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int          kind;
		logic [7:0]  bad;
		logic [31:0] ts;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A bad start byte locks the block until reset, and reset comes only once,
		// so the seed picks either the sync error session or the framed session
		if ($urandom_range(0, 9) == 0) begin
			push_byte(tfd_pkg::CR_BYTE);
			push_byte(tfd_pkg::LF_BYTE);
			do bad = 8'($urandom_range(0, 255));
			while (bad == tfd_pkg::START_BYTE || bad == tfd_pkg::CR_BYTE ||
			       bad == tfd_pkg::LF_BYTE);
			push_byte(bad);
			repeat (590) push_byte(8'($urandom_range(0, 255)));
			idle_on = 1'b0;
			push_byte(tfd_pkg::START_BYTE);
			push_byte(tfd_pkg::CR_BYTE);
		end else begin
			// directed: newlines in sync wait, null, empty, shortest frames
			push_byte(tfd_pkg::CR_BYTE);
			push_byte(tfd_pkg::LF_BYTE);
			push_byte(tfd_pkg::START_BYTE);
			send_frame(32'hFFFF_FFFF, 15'd0, 1'b0);
			send_frame(32'h0000_0000, 15'd0, 1'b1);
			send_frame(32'h1234_5678, 15'd1, 1'b0);
			send_frame(32'h8000_0001, 15'd2, 1'b1);

			// random frames, mostly short payloads
			while (items_sent < 300) begin
				kind = $urandom_range(0, 15);
				ts   = $urandom();
				case (kind)
					0:       send_frame(ts, 15'd0, 1'b0);
					1:       send_frame(ts, 15'd0, 1'b1);
					2:       send_frame(ts, 15'($urandom_range(1, 127)), 1'b0);
					3:       send_frame(ts, 15'($urandom_range(128, 400)), 1'b1);
					4, 5, 6: send_frame(ts, 15'($urandom_range(1, 12)), 1'b1);
					default: send_frame(ts, 15'($urandom_range(1, 12)), 1'b0);
				endcase
			end

			// back-to-back tail: a long frame, then a short and a null frame
			idle_on = 1'b0;
			send_frame($urandom(), 15'd280, 1'b1);
			send_frame($urandom(), 15'd3, 1'b0);
			send_frame($urandom(), 15'd0, 1'b0);
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then watch for stray words
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("timestamped_frame_deframer_core regression: pass");
		else
			$display("timestamped_frame_deframer_core regression: fail");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("timestamped_frame_deframer_core regression: fail");
		$finish;
	end

endmodule
